// ----- design/tsm_pkg.sv -----
// tsm_pkg: shared types and constants of the timestamp window matcher
// no dependencies; imported by every module of the block but tsm_mem
package tsm_pkg;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned UTC_W  = 25;
  localparam int unsigned WIN_W  = 20;

  // match window after reset, in microseconds
  localparam logic [WIN_W-1:0] WIN_RESET = 20'd50000;

  // event kinds
  localparam logic FUNC_SYNC = 1'b0;
  localparam logic FUNC_GNSS = 1'b1;

  // one entry of the sync pulse queue
  typedef struct packed {
    logic [TIME_W-1:0] hw_time;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] sys_time;
  } tsm_pulse_t;

  // one entry of the gnss queue
  typedef struct packed {
    logic [UTC_W-1:0]  utc;
    logic [TIME_W-1:0] sys_time;
  } tsm_gnss_t;

  // one matched pair
  typedef struct packed {
    logic [TIME_W-1:0] imu_hw_time;
    logic [TIME_W-1:0] imu_sys_time;
    logic [SEQ_W-1:0]  pulse_seq;
    logic [UTC_W-1:0]  gnss_utc;
    logic [TIME_W-1:0] gnss_sys_time;
  } tsm_rec_t;

  // scan control to result staging
  typedef struct packed {
    logic     match;  // new matched pair in rec
    logic     flush;  // scan of this event is over
    tsm_rec_t rec;
  } tsm_res_cmd_t;

  // scan sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_GRD,
    S_GLAT,
    S_PRD,
    S_PCMP,
    S_FIN
  } tsm_state_e;

endpackage

// ----- design/timestamp_window_matcher.sv -----
// sync pulse event: taken while idle, busy stays low, no result.
// gnss event: busy while G gnss entries are examined and P pulse entries
// compared; each compare waits on one read of the pulse memory.
// a non-final result strobes in the cycle after its successor is found; the final
// one in the first cycle busy is low again. results cannot be stalled.
// reset (async, active low): both queues empty, match window 50000 us.
module timestamp_window_matcher import tsm_pkg::*; #(
  parameter int unsigned GNSS_DEPTH  = 16,
  parameter int unsigned PULSE_DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WIN_W-1:0]  cfg_wdata_i,
  input  logic              start,
  output logic              busy,
  input  logic              func_i,
  input  logic [TIME_W-1:0] event_sys_time_i,
  input  logic [TIME_W-1:0] imu_hw_time_i,
  input  logic [SEQ_W-1:0]  pulse_seq_i,
  input  logic [UTC_W-1:0]  gnss_utc_i,
  output logic              result_valid_o,
  output logic [TIME_W-1:0] out_imu_hw_time_o,
  output logic [TIME_W-1:0] out_imu_sys_time_o,
  output logic [SEQ_W-1:0]  out_pulse_seq_o,
  output logic [UTC_W-1:0]  out_gnss_utc_o,
  output logic [TIME_W-1:0] out_gnss_sys_time_o,
  output logic              last_o
);

  localparam int unsigned PAW = $clog2(PULSE_DEPTH);
  localparam int unsigned GAW = $clog2(GNSS_DEPTH);

  logic [WIN_W-1:0] window_q;
  logic             pmem_we, pmem_re;
  logic [PAW-1:0]   pmem_waddr, pmem_raddr;
  tsm_pulse_t       pmem_wdata, pmem_rdata;
  logic             gmem_we, gmem_re;
  logic [GAW-1:0]   gmem_waddr, gmem_raddr;
  tsm_gnss_t        gmem_wdata, gmem_rdata;
  tsm_res_cmd_t     res_cmd;
  tsm_rec_t         rec;

  // match window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WIN_RESET;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  // pulse queue storage
  tsm_mem #(
    .DEPTH (PULSE_DEPTH),
    .WIDTH ($bits(tsm_pulse_t))
  ) u_pmem (
    .clk_i   (clk_i),
    .we_i    (pmem_we),
    .waddr_i (pmem_waddr),
    .wdata_i (pmem_wdata),
    .re_i    (pmem_re),
    .raddr_i (pmem_raddr),
    .rdata_o (pmem_rdata)
  );

  // gnss queue storage
  tsm_mem #(
    .DEPTH (GNSS_DEPTH),
    .WIDTH ($bits(tsm_gnss_t))
  ) u_gmem (
    .clk_i   (clk_i),
    .we_i    (gmem_we),
    .waddr_i (gmem_waddr),
    .wdata_i (gmem_wdata),
    .re_i    (gmem_re),
    .raddr_i (gmem_raddr),
    .rdata_o (gmem_rdata)
  );

  // queue pointers and scan
  tsm_ctrl #(
    .GNSS_DEPTH  (GNSS_DEPTH),
    .PULSE_DEPTH (PULSE_DEPTH)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .func_i           (func_i),
    .event_sys_time_i (event_sys_time_i),
    .imu_hw_time_i    (imu_hw_time_i),
    .pulse_seq_i      (pulse_seq_i),
    .gnss_utc_i       (gnss_utc_i),
    .window_i         (window_q),
    .busy             (busy),
    .pmem_we_o        (pmem_we),
    .pmem_waddr_o     (pmem_waddr),
    .pmem_wdata_o     (pmem_wdata),
    .pmem_re_o        (pmem_re),
    .pmem_raddr_o     (pmem_raddr),
    .pmem_rdata_i     (pmem_rdata),
    .gmem_we_o        (gmem_we),
    .gmem_waddr_o     (gmem_waddr),
    .gmem_wdata_o     (gmem_wdata),
    .gmem_re_o        (gmem_re),
    .gmem_raddr_o     (gmem_raddr),
    .gmem_rdata_i     (gmem_rdata),
    .res_cmd_o        (res_cmd)
  );

  // result staging
  tsm_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_cmd_i (res_cmd),
    .valid_o   (result_valid_o),
    .rec_o     (rec),
    .last_o    (last_o)
  );

  assign out_imu_hw_time_o   = rec.imu_hw_time;
  assign out_imu_sys_time_o  = rec.imu_sys_time;
  assign out_pulse_seq_o     = rec.pulse_seq;
  assign out_gnss_utc_o      = rec.gnss_utc;
  assign out_gnss_sys_time_o = rec.gnss_sys_time;

endmodule

// ----- design/tsm_mem.sv -----
// tsm_mem: simple dual port ram, one write port, one read port, registered read
// no dependencies; holds the entries of one ring queue
module tsm_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered output
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tsm_ctrl.sv -----
// tsm_ctrl: queue pointers and scan sequencer of the timestamp window matcher
// depends on tsm_pkg; drives the ports of the pulse and gnss queue memories
module tsm_ctrl import tsm_pkg::*; #(
  parameter int unsigned GNSS_DEPTH  = 16,
  parameter int unsigned PULSE_DEPTH = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic                           func_i,
  input  logic [TIME_W-1:0]              event_sys_time_i,
  input  logic [TIME_W-1:0]              imu_hw_time_i,
  input  logic [SEQ_W-1:0]               pulse_seq_i,
  input  logic [UTC_W-1:0]               gnss_utc_i,
  input  logic [WIN_W-1:0]               window_i,
  output logic                           busy,
  output logic                           pmem_we_o,
  output logic [$clog2(PULSE_DEPTH)-1:0] pmem_waddr_o,
  output tsm_pulse_t                     pmem_wdata_o,
  output logic                           pmem_re_o,
  output logic [$clog2(PULSE_DEPTH)-1:0] pmem_raddr_o,
  input  tsm_pulse_t                     pmem_rdata_i,
  output logic                           gmem_we_o,
  output logic [$clog2(GNSS_DEPTH)-1:0]  gmem_waddr_o,
  output tsm_gnss_t                      gmem_wdata_o,
  output logic                           gmem_re_o,
  output logic [$clog2(GNSS_DEPTH)-1:0]  gmem_raddr_o,
  input  tsm_gnss_t                      gmem_rdata_i,
  output tsm_res_cmd_t                   res_cmd_o
);

  localparam int unsigned PAW = $clog2(PULSE_DEPTH);
  localparam int unsigned PCW = $clog2(PULSE_DEPTH + 1);
  localparam int unsigned PSW = PAW + 1;
  localparam int unsigned GAW = $clog2(GNSS_DEPTH);
  localparam int unsigned GCW = $clog2(GNSS_DEPTH + 1);
  localparam int unsigned GSW = GAW + 1;

  tsm_state_e         state_q, state_d;
  logic [PAW-1:0]     phead_q, phead_d;
  logic [PCW-1:0]     pcnt_q, pcnt_d;
  logic [GAW-1:0]     ghead_q, ghead_d;
  logic [GCW-1:0]     gcnt_q, gcnt_d;
  logic [PCW-1:0]     j_q, j_d;
  logic [TIME_W:0]    gplus_q, gplus_d;
  logic               p_late;
  logic               p_hit;
  logic [PCW-1:0]     pop_n;

  // ring offset: base + off wraps once at most
  function automatic logic [PAW-1:0] pwrap(input logic [PAW-1:0] base,
                                           input logic [PCW-1:0] off);
    logic [PSW-1:0] sum;
    sum = PSW'(base) + PSW'(off);
    if (sum >= PSW'(PULSE_DEPTH)) begin
      sum = sum - PSW'(PULSE_DEPTH);
    end
    return sum[PAW-1:0];
  endfunction

  function automatic logic [GAW-1:0] gwrap(input logic [GAW-1:0] base,
                                           input logic [GCW-1:0] off);
    logic [GSW-1:0] sum;
    sum = GSW'(base) + GSW'(off);
    if (sum >= GSW'(GNSS_DEPTH)) begin
      sum = sum - GSW'(GNSS_DEPTH);
    end
    return sum[GAW-1:0];
  endfunction

  // window compares against the pulse entry just read
  assign p_late = gplus_q < {1'b0, pmem_rdata_i.sys_time};
  assign p_hit  = {1'b0, gmem_rdata_i.sys_time}
                < ({1'b0, pmem_rdata_i.sys_time} + (TIME_W + 1)'(window_i));
  assign pop_n  = p_late ? j_q : j_q + PCW'(1);

  assign busy = (state_q != S_IDLE);

  // state and pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phead_q <= '0;
      pcnt_q  <= '0;
      ghead_q <= '0;
      gcnt_q  <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      phead_q <= phead_d;
      pcnt_q  <= pcnt_d;
      ghead_q <= ghead_d;
      gcnt_q  <= gcnt_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gplus_q <= gplus_d;
  end

  // memory writes happen only in idle and reads only while busy,
  // so a read never overlaps a write of the same entry
  always_comb begin
    state_d      = state_q;
    phead_d      = phead_q;
    pcnt_d       = pcnt_q;
    ghead_d      = ghead_q;
    gcnt_d       = gcnt_q;
    j_d          = j_q;
    gplus_d      = gplus_q;
    pmem_we_o    = 1'b0;
    pmem_waddr_o = pwrap(phead_q, pcnt_q);
    pmem_wdata_o = '{hw_time: imu_hw_time_i, seq: pulse_seq_i,
                     sys_time: event_sys_time_i};
    pmem_re_o    = 1'b0;
    pmem_raddr_o = pwrap(phead_q, j_q);
    gmem_we_o    = 1'b0;
    gmem_waddr_o = gwrap(ghead_q, gcnt_q);
    gmem_wdata_o = '{utc: gnss_utc_i, sys_time: event_sys_time_i};
    gmem_re_o    = 1'b0;
    gmem_raddr_o = ghead_q;
    res_cmd_o    = '0;
    res_cmd_o.rec = '{imu_hw_time:   pmem_rdata_i.hw_time,
                      imu_sys_time:  pmem_rdata_i.sys_time,
                      pulse_seq:     pmem_rdata_i.seq,
                      gnss_utc:      gmem_rdata_i.utc,
                      gnss_sys_time: gmem_rdata_i.sys_time};

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (func_i == FUNC_SYNC) begin
            // push pulse, full queue drops its oldest entry
            pmem_we_o = 1'b1;
            if (pcnt_q == PCW'(PULSE_DEPTH)) begin
              phead_d = pwrap(phead_q, PCW'(1));
            end else begin
              pcnt_d = pcnt_q + PCW'(1);
            end
          end else begin
            gmem_we_o = 1'b1;
            if (gcnt_q == GCW'(GNSS_DEPTH)) begin
              ghead_d = gwrap(ghead_q, GCW'(1));
            end else begin
              gcnt_d = gcnt_q + GCW'(1);
            end
            state_d = S_GRD;
          end
        end
      end
      S_GRD: begin
        // fetch the oldest pending gnss entry
        if (gcnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          gmem_re_o = 1'b1;
          state_d   = S_GLAT;
        end
      end
      S_GLAT: begin
        gplus_d = {1'b0, gmem_rdata_i.sys_time} + (TIME_W + 1)'(window_i);
        j_d     = '0;
        state_d = S_PRD;
      end
      S_PRD: begin
        // every pulse too early: clear pulse queue, keep gnss entries
        if (j_q == pcnt_q) begin
          phead_d = '0;
          pcnt_d  = '0;
          state_d = S_FIN;
        end else begin
          pmem_re_o = 1'b1;
          state_d   = S_PCMP;
        end
      end
      S_PCMP: begin
        if (p_late || p_hit) begin
          // pop scanned pulses and retire the gnss entry
          phead_d = pwrap(phead_q, pop_n);
          pcnt_d  = pcnt_q - pop_n;
          ghead_d = gwrap(ghead_q, GCW'(1));
          gcnt_d  = gcnt_q - GCW'(1);
          res_cmd_o.match = !p_late;
          state_d = S_GRD;
        end else begin
          j_d     = j_q + PCW'(1);
          state_d = S_PRD;
        end
      end
      S_FIN: begin
        res_cmd_o.flush = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/tsm_out.sv -----
// tsm_out: result staging, holds one match back until its last flag is known
// depends on tsm_pkg; fed by tsm_ctrl
module tsm_out import tsm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tsm_res_cmd_t res_cmd_i,
  output logic         valid_o,
  output tsm_rec_t     rec_o,
  output logic         last_o
);

  logic     hold_v_q, hold_v_d;
  tsm_rec_t hold_q, hold_d;
  logic     out_v_q, out_v_d;
  tsm_rec_t out_q, out_d;
  logic     last_q, last_d;

  // a new match pushes the held one out, end of scan releases it as last
  always_comb begin
    hold_v_d = hold_v_q;
    hold_d   = hold_q;
    out_v_d  = 1'b0;
    out_d    = out_q;
    last_d   = last_q;
    if (res_cmd_i.match) begin
      hold_v_d = 1'b1;
      hold_d   = res_cmd_i.rec;
      if (hold_v_q) begin
        out_v_d = 1'b1;
        out_d   = hold_q;
        last_d  = 1'b0;
      end
    end else if (res_cmd_i.flush) begin
      hold_v_d = 1'b0;
      if (hold_v_q) begin
        out_v_d = 1'b1;
        out_d   = hold_q;
        last_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
    last_q <= last_d;
  end

  assign valid_o = out_v_q;
  assign rec_o   = out_q;
  assign last_o  = last_q;

endmodule

// ----- design/tsm_checker.sv -----
// tsm_checker: port level checks of the timestamp window matcher
// depends on tsm_pkg; bound to timestamp_window_matcher at the end of this file
module tsm_checker import tsm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic func_i,
  input logic result_valid_o,
  input logic last_o
);

  // a sync pulse transaction never makes the block busy
  a_sync_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FUNC_SYNC) |=> !busy)
    else $error("busy after sync pulse transaction");

  // a gnss transaction always starts a scan
  a_gnss_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FUNC_GNSS) |=> busy)
    else $error("no scan after gnss transaction");

  // more results pending means the scan is still running
  a_nonlast_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy)
    else $error("non-final result while idle");

  // the final result comes after the scan has ended
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy)
    else $error("final result while busy");

  // nothing follows directly after a final result
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o)
    else $error("result right after final result");

endmodule

bind timestamp_window_matcher tsm_checker u_tsm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .func_i         (func_i),
  .result_valid_o (result_valid_o),
  .last_o         (last_o)
);
